// ===== src/nfbs_pkg.sv =====
`timescale 1ns / 1ps
// nfbs_pkg: shared constants and codes for the nor flash byte store
// used by nor_flash_byte_store_top and tb_top; no dependencies

package nfbs_pkg;

  // array geometry, sector size is a power of two
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned SECTOR_COUNT = 8;
  localparam int unsigned TOTAL_BYTES  = SECTOR_BYTES * SECTOR_COUNT;

  localparam int unsigned SECTOR_AW = $clog2(SECTOR_BYTES);
  localparam int unsigned FLASH_AW  = (TOTAL_BYTES > 1) ? $clog2(TOTAL_BYTES) : 1;
  localparam int unsigned CNT_AW    = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;

  // item field widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;

  localparam logic [BYTE_W-1:0]  ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_COUNT   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_SETBIT = 2'd2,
    ST_ALIGN  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_ACCESS = 2'd2,
    S_ERASE  = 2'd3
  } state_e;

endpackage

// ===== src/nfbs_ram.sv =====
`timescale 1ns / 1ps
// nfbs_ram: generic single-write, single-read ram with registered read data
// no dependencies

module nfbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/nor_flash_byte_store_top.sv =====
`timescale 1ns / 1ps
// nor_flash_byte_store_top: byte-wide nor flash array with per-sector erase counters
// depends on nfbs_pkg and nfbs_ram
// result: an accepted item is held and its result registered once the output is free
// throughput: byte reads, programs, count reads and failed items run one item per
//   cycle while the output is not stalled, bound by the single read port of the
//   flash ram; a successful erase holds off input for the sector sweep in S_ERASE,
//   and the next item is taken in S_IDLE after it
// reset: asynchronous active low; afterwards a clearing pass writes 0xFF to every
//   byte and zero to every counter before any item is taken

module nor_flash_byte_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] address, [23:16] data
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  input  logic        s_axis_tlast,  // burst_end
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] read_data
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast   // last_of_run
);

  localparam int unsigned FAW = nfbs_pkg::FLASH_AW;
  localparam int unsigned CAW = nfbs_pkg::CNT_AW;
  localparam int unsigned SAW = nfbs_pkg::SECTOR_AW;

  // control state
  nfbs_pkg::state_e state_q, state_d;
  logic [FAW-1:0]   ptr_q, ptr_d;   // clearing pass and erase sweep pointer
  logic             out_valid_q, out_valid_d;
  logic             fwd_q, fwd_d;   // program write-back to the byte just read

  // item registers
  nfbs_pkg::action_e              act_q;
  logic [nfbs_pkg::ADDR_W-1:0]    addr_q;
  logic [nfbs_pkg::BYTE_W-1:0]    data_q;
  logic                           last_q;
  logic [nfbs_pkg::BYTE_W-1:0]    fwd_data_q, fwd_data_d;

  // result register
  nfbs_pkg::status_e              status_q, status_d;
  logic [nfbs_pkg::COUNT_W-1:0]   rdata_q, rdata_d;
  logic                           res_last_q;

  // ram ports
  logic                           flash_we;
  logic [FAW-1:0]                 flash_waddr, flash_raddr;
  logic [nfbs_pkg::BYTE_W-1:0]    flash_wdata, flash_rdata;
  logic                           cnt_we;
  logic [CAW-1:0]                 cnt_waddr, cnt_raddr;
  logic [nfbs_pkg::COUNT_W-1:0]   cnt_wdata, cnt_rdata;

  // decode of the held item
  logic                           in_hs;
  logic                           can_finish;
  logic                           erase_go;
  logic                           prog_go;
  logic [31:0]                    addr_ext, sector;
  logic [31:0]                    in_addr_ext, in_sector;
  logic                           in_range, aligned;
  logic [nfbs_pkg::BYTE_W-1:0]    stored, programmed;

  assign in_hs       = s_axis_tvalid & s_axis_tready;
  assign can_finish  = ~out_valid_q | m_axis_tready;

  assign addr_ext    = 32'(addr_q);
  assign sector      = addr_ext >> SAW;
  assign in_range    = addr_ext < nfbs_pkg::TOTAL_BYTES;
  assign aligned     = (addr_ext[SAW-1:0] == '0);
  assign in_addr_ext = 32'(s_axis_tdata[15:0]);
  assign in_sector   = in_addr_ext >> SAW;

  // the ram read does not see a write made at the same edge; forward the byte just programmed
  assign stored      = fwd_q ? fwd_data_q : flash_rdata;
  assign programmed  = stored & data_q;

  // result of the held item
  always_comb begin
    status_d = nfbs_pkg::ST_OK;
    rdata_d  = '0;
    erase_go = 1'b0;
    prog_go  = 1'b0;
    if (!in_range) begin
      status_d = nfbs_pkg::ST_RANGE;
    end else begin
      case (act_q)
        nfbs_pkg::ACT_READ: begin
          rdata_d = 32'(stored);
        end
        nfbs_pkg::ACT_PROGRAM: begin
          // a program may only clear bits
          if ((~stored & data_q) != '0) begin
            status_d = nfbs_pkg::ST_SETBIT;
          end else begin
            prog_go = 1'b1;
          end
        end
        nfbs_pkg::ACT_ERASE: begin
          if (!aligned) begin
            status_d = nfbs_pkg::ST_ALIGN;
          end else begin
            erase_go = 1'b1;
          end
        end
        default: begin
          rdata_d = cnt_rdata;
        end
      endcase
    end
  end

  // sequencer: next state, ram ports, handshakes
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    out_valid_d   = out_valid_q & ~m_axis_tready;
    fwd_d         = 1'b0;
    fwd_data_d    = programmed;
    s_axis_tready = 1'b0;
    flash_we      = 1'b0;
    flash_waddr   = ptr_q;
    flash_wdata   = nfbs_pkg::ERASED_BYTE;
    cnt_we        = 1'b0;
    cnt_waddr     = ptr_q[CAW-1:0];
    cnt_wdata     = '0;

    unique case (state_q)
      nfbs_pkg::S_CLEAR: begin
        flash_we = 1'b1;
        cnt_we   = (32'(ptr_q) < nfbs_pkg::SECTOR_COUNT);
        ptr_d    = ptr_q + 1'b1;
        if (ptr_q == FAW'(nfbs_pkg::TOTAL_BYTES - 1)) begin
          state_d = nfbs_pkg::S_IDLE;
        end
      end
      nfbs_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = nfbs_pkg::S_ACCESS;
        end
      end
      nfbs_pkg::S_ACCESS: begin
        if (can_finish) begin
          out_valid_d = 1'b1;
          if (prog_go) begin
            flash_we    = 1'b1;
            flash_waddr = addr_ext[FAW-1:0];
            flash_wdata = programmed;
          end
          if (erase_go) begin
            cnt_we    = 1'b1;
            cnt_waddr = sector[CAW-1:0];
            cnt_wdata = cnt_rdata + 1'b1;
            ptr_d     = addr_ext[FAW-1:0];
            state_d   = nfbs_pkg::S_ERASE;
          end else begin
            // next item may enter while this result goes out
            s_axis_tready = 1'b1;
            if (s_axis_tvalid) begin
              fwd_d = prog_go & (s_axis_tdata[15:0] == addr_q);
            end else begin
              state_d = nfbs_pkg::S_IDLE;
            end
          end
        end
      end
      nfbs_pkg::S_ERASE: begin
        flash_we = 1'b1;
        ptr_d    = ptr_q + 1'b1;
        if (ptr_q[SAW-1:0] == '1) begin
          state_d = nfbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nfbs_pkg::S_IDLE;
      end
    endcase
  end

  // read the incoming item's byte and counter while it is accepted
  assign flash_raddr = in_hs ? in_addr_ext[FAW-1:0] : addr_ext[FAW-1:0];
  assign cnt_raddr   = in_hs ? in_sector[CAW-1:0] : sector[CAW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nfbs_pkg::S_CLEAR;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      act_q  <= nfbs_pkg::action_e'(s_axis_tuser);
      addr_q <= s_axis_tdata[15:0];
      data_q <= s_axis_tdata[23:16];
      last_q <= s_axis_tlast;
    end
    fwd_data_q <= fwd_data_d;
    if ((state_q == nfbs_pkg::S_ACCESS) && can_finish) begin
      status_q   <= status_d;
      rdata_q    <= rdata_d;
      res_last_q <= last_q;
    end
  end

  nfbs_ram #(
    .WIDTH (nfbs_pkg::BYTE_W),
    .DEPTH (nfbs_pkg::TOTAL_BYTES)
  ) u_flash_ram (
    .clk_i   (clk_i),
    .we_i    (flash_we),
    .waddr_i (flash_waddr),
    .wdata_i (flash_wdata),
    .raddr_i (flash_raddr),
    .rdata_o (flash_rdata)
  );

  nfbs_ram #(
    .WIDTH (nfbs_pkg::COUNT_W),
    .DEPTH (nfbs_pkg::SECTOR_COUNT)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rdata_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = res_last_q;

`ifndef SYNTHESIS
  // no item enters during the clearing pass or an erase sweep
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |-> (state_q == nfbs_pkg::S_IDLE || state_q == nfbs_pkg::S_ACCESS))
    else $error("item accepted while array busy");

  // forwarding only follows a program write-back in the previous cycle
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> ($past(flash_we) && $past(state_q) == nfbs_pkg::S_ACCESS))
    else $error("forwarding without a program write");

  // counters change only in the clearing pass or when an erase starts
  a_cnt_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (state_q == nfbs_pkg::S_CLEAR ||
                (state_q == nfbs_pkg::S_ACCESS && erase_go && can_finish)))
    else $error("unexpected counter write");

  // an erase sweep starts on a sector boundary
  a_erase_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfbs_pkg::S_ACCESS && state_d == nfbs_pkg::S_ERASE)
      |=> (ptr_q[SAW-1:0] == '0))
    else $error("erase sweep not sector aligned");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> ($stable(rdata_q) && $stable(status_q)))
    else $error("pending result overwritten");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for nor_flash_byte_store_top, with a byte-level flash predictor
// depends on nfbs_pkg and nor_flash_byte_store_top; runs directed, random and backpressure items

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  // one expected result, fields as the block returns them
  typedef struct packed {
    nfbs_pkg::status_e status;
    logic [31:0]       read_data;
    logic              last_of_run;
  } flash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [15:0] address, [23:16] data
  logic [1:0]  s_axis_tuser = nfbs_pkg::ACT_READ;  // [1:0] action
  logic        s_axis_tlast = 1'b0;  // burst_end

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // [31:0] read_data
  logic [1:0]  m_axis_tuser;  // [1:0] status
  logic        m_axis_tlast;  // last_of_run

  nor_flash_byte_store_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // predicted contents of the flash and its erase counters
  logic [7:0]  flash_bytes   [nfbs_pkg::TOTAL_BYTES];
  logic [31:0] sector_erases [nfbs_pkg::SECTOR_COUNT];

  flash_result_t pending_results[$];

  // idling knobs, percent of cycles
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  // long receiver hold-off, requested by the test and counted by the ready process
  int unsigned hold_request_id = 0;
  int unsigned hold_len        = 0;
  int unsigned hold_seen_id    = 0;
  int unsigned hold_left       = 0;

  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned erases_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nor_flash_byte_store_top test failed");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when the test asks for one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen_id != hold_request_id) begin
      hold_seen_id = hold_request_id;
      hold_left    = hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_result
    flash_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d read_data %h last_of_run %b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d actual %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.read_data) begin
          $error("read_data mismatch: expected %h actual %h", want.read_data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last_of_run) begin
          $error("last_of_run mismatch: expected %b actual %b",
                 want.last_of_run, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // predicted effect of one item on the array; returns the result it should give
  function automatic flash_result_t predict_flash_access(nfbs_pkg::action_e act,
                                                          logic [15:0] addr,
                                                          logic [7:0] data, logic last);
    flash_result_t res;
    int unsigned   sec;
    res.status      = nfbs_pkg::ST_OK;
    res.read_data   = '0;
    res.last_of_run = last;
    if (addr >= nfbs_pkg::TOTAL_BYTES) begin
      // out of range wins over every other check
      res.status = nfbs_pkg::ST_RANGE;
    end else begin
      sec = addr / nfbs_pkg::SECTOR_BYTES;
      case (act)
        nfbs_pkg::ACT_READ: begin
          res.read_data = {24'd0, flash_bytes[addr]};
        end
        nfbs_pkg::ACT_PROGRAM: begin
          // a program may only clear bits
          if ((~flash_bytes[addr] & data) != 8'd0) begin
            res.status = nfbs_pkg::ST_SETBIT;
          end else begin
            flash_bytes[addr] = flash_bytes[addr] & data;
          end
        end
        nfbs_pkg::ACT_ERASE: begin
          if ((addr % nfbs_pkg::SECTOR_BYTES) != 0) begin
            res.status = nfbs_pkg::ST_ALIGN;
          end else if (sec < nfbs_pkg::SECTOR_COUNT) begin
            for (int unsigned i = 0; i < nfbs_pkg::SECTOR_BYTES; i++) begin
              flash_bytes[addr + i] = nfbs_pkg::ERASED_BYTE;
            end
            sector_erases[sec] = sector_erases[sec] + 32'd1;
          end else begin
            res.status = nfbs_pkg::ST_RANGE;
          end
        end
        default: begin
          if (sec < nfbs_pkg::SECTOR_COUNT) begin
            res.read_data = sector_erases[sec];
          end else begin
            res.status = nfbs_pkg::ST_RANGE;
          end
        end
      endcase
    end
    return res;
  endfunction

  // offer one item, wait for it to be taken, then record what it should return
  task automatic send_item(nfbs_pkg::action_e act, logic [15:0] addr, logic [7:0] data,
                           logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_flash_access(act, addr, data, last));
    items_sent++;
    if (act == nfbs_pkg::ACT_ERASE) erases_sent++;
  endtask

  // start address of a run: mostly a small hot window so reads see earlier programs
  function automatic logic [15:0] pick_run_addr();
    int unsigned pick;
    int unsigned sec;
    pick = $urandom_range(0, 99);
    sec  = $urandom_range(0, nfbs_pkg::SECTOR_COUNT - 1);
    if (pick < 70) return 16'(sec * nfbs_pkg::SECTOR_BYTES + $urandom_range(0, 31));
    if (pick < 85)
      return 16'(sec * nfbs_pkg::SECTOR_BYTES + nfbs_pkg::SECTOR_BYTES
                 - $urandom_range(1, 8));
    return 16'($urandom_range(0, 65535));
  endfunction

  // runs of reads and programs with burst_end on the last byte, plus erases,
  // count reads and some noise
  task automatic run_flash_traffic(int unsigned n_items);
    int unsigned   stop_at;
    int unsigned   kind;
    int unsigned   run_len;
    logic [15:0]   addr;
    logic [7:0]    data;
    logic          last;
    logic          broken;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        run_len = $urandom_range(1, 8);
        addr    = pick_run_addr();
        broken  = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < run_len; i++) begin
          last = broken ? 1'($urandom_range(0, 1)) : (i == run_len - 1);
          if (kind < 40) begin
            send_item(nfbs_pkg::ACT_READ, addr, 8'($urandom_range(0, 255)), last);
          end else begin
            // mostly subsets of the stored byte, else anything
            if (addr < nfbs_pkg::TOTAL_BYTES && $urandom_range(0, 99) < 65)
              data = flash_bytes[addr] & 8'($urandom_range(0, 255));
            else
              data = 8'($urandom_range(0, 255));
            send_item(nfbs_pkg::ACT_PROGRAM, addr, data, last);
          end
          addr = addr + 16'd1;
        end
      end else if (kind < 83) begin
        if ($urandom_range(0, 99) < 85)
          addr = 16'($urandom_range(0, nfbs_pkg::TOTAL_BYTES - 1));
        else
          addr = 16'($urandom_range(nfbs_pkg::TOTAL_BYTES, 65535));
        send_item(nfbs_pkg::ACT_COUNT, addr, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (kind < 90) begin
        case ($urandom_range(0, 6))
          // almost always misaligned
          0: addr = 16'($urandom_range(0, nfbs_pkg::TOTAL_BYTES - 1));
          1: addr = 16'($urandom_range(nfbs_pkg::TOTAL_BYTES, 65535));
          2: addr = 16'(($urandom_range(nfbs_pkg::TOTAL_BYTES / nfbs_pkg::SECTOR_BYTES, 15))
                        * nfbs_pkg::SECTOR_BYTES);
          default: addr = 16'($urandom_range(0, nfbs_pkg::SECTOR_COUNT - 1)
                              * nfbs_pkg::SECTOR_BYTES);
        endcase
        send_item(nfbs_pkg::ACT_ERASE, addr, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(nfbs_pkg::action_e'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // extremes of address and data, every action, and each corner of the status rules
  task automatic test_directed_cases();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(nfbs_pkg::ACT_READ,    16'd0,                           8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_READ,    16'(nfbs_pkg::TOTAL_BYTES - 1),  8'hFF, 1'b1);
    // first address out of range
    send_item(nfbs_pkg::ACT_READ,    16'(nfbs_pkg::TOTAL_BYTES),      8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_READ,    16'hFFFF,                        8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_PROGRAM, 16'd0,                           8'hA5, 1'b0);
    // same byte again
    send_item(nfbs_pkg::ACT_PROGRAM, 16'd0,                           8'hA5, 1'b0);
    // subset of stored bits
    send_item(nfbs_pkg::ACT_PROGRAM, 16'd0,                           8'h21, 1'b0);
    // would set cleared bits
    send_item(nfbs_pkg::ACT_PROGRAM, 16'd0,                           8'hFF, 1'b1);
    send_item(nfbs_pkg::ACT_PROGRAM, 16'(nfbs_pkg::TOTAL_BYTES - 1),  8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_PROGRAM, 16'hFFFF,                        8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_READ,    16'd0,                           8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_READ,    16'(nfbs_pkg::TOTAL_BYTES - 1),  8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_COUNT,   16'd0,                           8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_ERASE,   16'd0,                           8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_COUNT,   16'(nfbs_pkg::SECTOR_BYTES - 1), 8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_READ,    16'd0,                           8'h00, 1'b0);
    // misaligned
    send_item(nfbs_pkg::ACT_ERASE,   16'd1,                           8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_ERASE,
              16'(nfbs_pkg::TOTAL_BYTES - nfbs_pkg::SECTOR_BYTES),    8'h00, 1'b1);
    // aligned, out of range
    send_item(nfbs_pkg::ACT_ERASE,   16'(nfbs_pkg::TOTAL_BYTES),      8'h00, 1'b0);
    // range wins over alignment
    send_item(nfbs_pkg::ACT_ERASE,   16'hFFFF,                        8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_READ,    16'(nfbs_pkg::TOTAL_BYTES - 1),  8'h00, 1'b0);
    send_item(nfbs_pkg::ACT_COUNT,   16'(nfbs_pkg::TOTAL_BYTES - 1),  8'h00, 1'b1);
    send_item(nfbs_pkg::ACT_COUNT,   16'hFFFF,                        8'h00, 1'b0);
  endtask

  task automatic test_random_phase(int unsigned n_items, int unsigned src_pct,
                                   int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    run_flash_traffic(n_items);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_len       = 600;
    hold_request_id++;
    run_flash_traffic(150);
  endtask

  initial begin
    for (int unsigned i = 0; i < nfbs_pkg::TOTAL_BYTES; i++)
      flash_bytes[i] = nfbs_pkg::ERASED_BYTE;
    for (int unsigned i = 0; i < nfbs_pkg::SECTOR_COUNT; i++) sector_erases[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_phase(300, 0, 0);
    test_random_phase(250, 83, 0);
    test_random_phase(250, 0, 83);
    test_random_phase(300, 13, 13);
    test_output_backpressure();
    s_axis_tvalid <= 1'b0;

    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d items (%0d erases): ok %0d, out of range %0d, set-bit %0d",
             items_sent, erases_sent, status_seen[nfbs_pkg::ST_OK],
             status_seen[nfbs_pkg::ST_RANGE], status_seen[nfbs_pkg::ST_SETBIT]);
    $display("misaligned %0d; idling phases and one %0d-cycle receiver hold-off included",
             status_seen[nfbs_pkg::ST_ALIGN], hold_len);
    if (fail_count == 0) begin
      $display("nor_flash_byte_store_top test passed");
    end else begin
      $display("nor_flash_byte_store_top test failed");
    end
    $finish;
  end

endmodule
